@@ design/ctok_pkg.sv @@
// ctok_pkg: shared types, token class codes and keyword table for the token scanner
// used by ctok_front, ctok_queue, ctok_back and c_token_scanner_top
// no dependencies
package ctok_pkg;

  // defaults for the top-level parameters
  localparam int WORD_MAX_DEF   = 29;
  localparam int COUNT_BITS_DEF = 16;

  // token class codes
  localparam logic [2:0] CLS_OPER  = 3'd0;
  localparam logic [2:0] CLS_SYMB  = 3'd1;
  localparam logic [2:0] CLS_DIGIT = 3'd2;
  localparam logic [2:0] CLS_KEYW  = 3'd3;
  localparam logic [2:0] CLS_IDENT = 3'd4;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // commands passed from front to back
  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_APPEND  = 3'd1,
    OP_FLUSH   = 3'd2,
    OP_SINGLE  = 3'd3,
    OP_NEWLINE = 3'd4
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] cls;
    logic [7:0] ch;
  } cmd_t;

  // keyword table, left justified and zero padded to six characters
  localparam int KW_NUM   = 9;
  localparam int KW_CHARS = 6;
  localparam int KW_BITS  = KW_CHARS * 8;

  localparam logic [KW_BITS-1:0] KW_TEXT [KW_NUM] = '{
    {"int",    24'h0},
    {"main",   16'h0},
    {"void",   16'h0},
    {"return"},
    {"if",     32'h0},
    {"else",   16'h0},
    {"printf"},
    {"goto",   16'h0},
    {"switch"}
  };

  localparam logic [2:0] KW_LEN [KW_NUM] = '{
    3'd3, 3'd4, 3'd4, 3'd6, 3'd2, 3'd4, 3'd6, 3'd4, 3'd6
  };

  // true when the word prefix and length match one of the keywords
  function automatic logic is_keyword(input logic [KW_BITS-1:0] word,
                                      input logic [5:0] len);
    logic hit;
    logic match;
    hit = 1'b0;
    for (int k = 0; k < KW_NUM; k++) begin
      match = (6'(KW_LEN[k]) == len);
      for (int i = 0; i < KW_CHARS; i++) begin
        if ((i < int'(KW_LEN[k])) &&
            (word[KW_BITS-1-8*i -: 8] != KW_TEXT[k][KW_BITS-1-8*i -: 8])) begin
          match = 1'b0;
        end
      end
      hit = hit | match;
    end
    return hit;
  endfunction

endpackage

@@ design/ctok_front.sv @@
// ctok_front: accepts text items, tracks word state and turns each byte into commands
// depends on ctok_pkg; feeds ctok_queue
module ctok_front import ctok_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  logic in_word;
  logic in_word_next;
  logic hold_valid;
  cmd_t hold_cmd;

  logic accept;
  logic is_letter, is_digit, is_alnum;
  logic is_oper, is_symb, is_nl;
  logic cls_valid;
  cmd_t cls_cmd;
  logic first_valid, second_valid;
  cmd_t first_cmd, second_cmd;

  // byte classes
  always_comb begin
    is_letter = ((text_byte >= "A") && (text_byte <= "Z")) ||
                ((text_byte >= "a") && (text_byte <= "z"));
    is_digit  = (text_byte >= "0") && (text_byte <= "9");
    is_alnum  = is_letter || is_digit;
    is_oper   = (text_byte == "+") || (text_byte == "-") || (text_byte == "*") ||
                (text_byte == "/") || (text_byte == "^");
    is_symb   = (text_byte == "{") || (text_byte == "}") || (text_byte == "(") ||
                (text_byte == ")") || (text_byte == ";") || (text_byte == ",") ||
                (text_byte == "#");
    is_nl     = (text_byte == 8'h0a);
  end

  // command for a byte seen outside a word
  always_comb begin
    cls_valid   = 1'b1;
    cls_cmd.ch  = text_byte;
    cls_cmd.cls = CLS_OPER;
    cls_cmd.op  = OP_SINGLE;
    if (is_oper) begin
      cls_cmd.cls = CLS_OPER;
    end else if (is_symb) begin
      cls_cmd.cls = CLS_SYMB;
    end else if (is_digit) begin
      cls_cmd.cls = CLS_DIGIT;
    end else if (is_nl) begin
      cls_cmd.op = OP_NEWLINE;
    end else if (is_letter) begin
      cls_cmd.op = OP_START;
    end else begin
      cls_valid = 1'b0;
    end
  end

  // up to two commands per item: a word flush, then the ending byte
  always_comb begin
    first_valid    = 1'b0;
    first_cmd      = cls_cmd;
    second_valid   = 1'b0;
    second_cmd     = cls_cmd;
    in_word_next   = in_word;
    if (end_of_text) begin
      first_valid  = in_word;
      first_cmd.op = OP_FLUSH;
      in_word_next = 1'b0;
    end else if (in_word && is_alnum) begin
      first_valid  = 1'b1;
      first_cmd.op = OP_APPEND;
    end else if (in_word) begin
      first_valid  = 1'b1;
      first_cmd.op = OP_FLUSH;
      second_valid = cls_valid;
      in_word_next = is_letter;
    end else begin
      first_valid  = cls_valid;
      in_word_next = is_letter;
    end
  end

  assign text_stall = hold_valid || q_full;
  assign accept     = text_valid && !text_stall;

  // push the held second command first, else the item's first command
  always_comb begin
    if (hold_valid) begin
      push     = !q_full;
      push_cmd = hold_cmd;
    end else begin
      push     = accept && first_valid;
      push_cmd = first_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_word    <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (accept) begin
        in_word <= in_word_next;
      end
      if (hold_valid && !q_full) begin
        hold_valid <= 1'b0;
      end else if (accept && second_valid) begin
        hold_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && second_valid) begin
      hold_cmd <= second_cmd;
    end
  end

`ifndef SYNTH
  // a held command always blocks the next item
  assert property (@(posedge clk) disable iff (rst) hold_valid |-> text_stall)
    else $error("front took an item while a command was held");
`endif

endmodule

@@ design/ctok_queue.sv @@
// ctok_queue: short command queue between the front and back parts
// depends on ctok_pkg
module ctok_queue import ctok_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic full,
  output logic empty
);

  cmd_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign full     = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign head_cmd = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command pushed into a full queue");
`endif
`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command popped from an empty queue");
`endif
`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst) count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue fill count out of range");
`endif

endmodule

@@ design/ctok_back.sv @@
// ctok_back: executes queued commands, buffers words, matches keywords, emits token items
// depends on ctok_pkg; fed by ctok_queue
module ctok_back import ctok_pkg::*; #(
  parameter int WORD_MAX   = WORD_MAX_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  cmd_t        head_cmd,
  output logic        pop,
  output logic        token_valid,
  input  logic        token_stall,
  output logic [15:0] line_number,
  output logic [15:0] token_number,
  output logic [2:0]  token_class,
  output logic [7:0]  lexeme_char,
  output logic        last_char
);

  localparam int IDX_BITS = $clog2(WORD_MAX);
  localparam int LEN_BITS = $clog2(WORD_MAX + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_SHOW = 3'b100
  } state_t;

  state_t                state;
  logic [LEN_BITS-1:0]   len;
  logic [IDX_BITS-1:0]   idx;
  logic                  word_mode;
  logic [2:0]            cur_cls;
  logic [7:0]            cur_ch;
  logic [COUNT_BITS-1:0] line_count;
  logic [COUNT_BITS-1:0] token_count;
  logic [KW_BITS-1:0]    prefix;
  logic [7:0]            word_mem [WORD_MAX];
  logic [7:0]            rd_data;

  logic                  wr_en;
  logic                  at_last;
  logic                  kw_hit;

  assign pop     = (state == S_IDLE) && !q_empty;
  assign kw_hit  = is_keyword(prefix, 6'(len));
  assign at_last = ((LEN_BITS'(idx) + LEN_BITS'(1)) == len);
  assign wr_en   = pop && (((head_cmd.op == OP_APPEND) && (len < LEN_BITS'(WORD_MAX))) ||
                           (head_cmd.op == OP_START));

  // output item
  assign token_valid  = (state == S_SHOW);
  assign line_number  = 16'(line_count);
  assign token_number = 16'(token_count);
  assign token_class  = cur_cls;
  assign lexeme_char  = word_mode ? rd_data : cur_ch;
  assign last_char    = !word_mode || at_last;

  // control and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      len         <= '0;
      idx         <= '0;
      word_mode   <= 1'b0;
      line_count  <= COUNT_BITS'(1);
      token_count <= COUNT_BITS'(1);
    end else begin
      case (state)
        S_IDLE: begin
          if (pop) begin
            case (head_cmd.op)
              OP_START: begin
                len <= LEN_BITS'(1);
              end
              OP_APPEND: begin
                if (len < LEN_BITS'(WORD_MAX)) begin
                  len <= len + LEN_BITS'(1);
                end
              end
              OP_NEWLINE: begin
                if (line_count != '1) begin
                  line_count <= line_count + COUNT_BITS'(1);
                end
              end
              OP_SINGLE: begin
                word_mode <= 1'b0;
                state     <= S_SHOW;
              end
              OP_FLUSH: begin
                word_mode <= 1'b1;
                idx       <= '0;
                state     <= S_READ;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_SHOW;
        end
        S_SHOW: begin
          if (!token_stall) begin
            if (!word_mode || at_last) begin
              if (token_count != '1) begin
                token_count <= token_count + COUNT_BITS'(1);
              end
              if (word_mode) begin
                len <= '0;
              end
              state <= S_IDLE;
            end else begin
              idx   <= idx + IDX_BITS'(1);
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // class and character of the current token
  always_ff @(posedge clk) begin
    if (pop && (head_cmd.op == OP_SINGLE)) begin
      cur_cls <= head_cmd.cls;
      cur_ch  <= head_cmd.ch;
    end else if (pop && (head_cmd.op == OP_FLUSH)) begin
      cur_cls <= kw_hit ? CLS_KEYW : CLS_IDENT;
    end
  end

  // keyword prefix copy of the first characters
  always_ff @(posedge clk) begin
    if (pop && (head_cmd.op == OP_START)) begin
      prefix[KW_BITS-1 -: 8] <= head_cmd.ch;
    end else if (pop && (head_cmd.op == OP_APPEND) && (len < LEN_BITS'(KW_CHARS))) begin
      prefix[8*(KW_CHARS-1-int'(len)) +: 8] <= head_cmd.ch;
    end
  end

  // word buffer with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (head_cmd.op == OP_START) begin
        word_mem[0] <= head_cmd.ch;
      end else begin
        word_mem[len[IDX_BITS-1:0]] <= head_cmd.ch;
      end
    end
    rd_data <= word_mem[idx];
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
                   (state == S_SHOW) && word_mode |-> (LEN_BITS'(idx) < len))
    else $error("word character index beyond word length");
`endif
`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
                   token_valid && token_stall |=> token_valid && $stable(lexeme_char))
    else $error("stalled token item changed");
`endif
`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
                   !$past(rst) |-> token_count >= $past(token_count))
    else $error("token count went backward");
`endif

endmodule

@@ design/c_token_scanner_top.sv @@
// c_token_scanner_top: byte-serial lexical analyzer, top level
// depends on ctok_pkg, ctok_front, ctok_queue, ctok_back
//
//   channel  direction  handshake                payload
//   text     in         text_valid/text_stall    text_byte, end_of_text
//   token    out        token_valid/token_stall  line_number, token_number, token_class,
//                                                lexeme_char, last_char
//
// the front takes one text item per cycle unless the four-entry queue is full or a
// command is held; an operator, symbol or newline that ends a word pushes two commands
// and blocks the next item until the second is pushed. the back pops a word or newline
// command, pops then shows a single token, pops a flush then reads and shows each character.
// reset (rst, synchronous) sets both counters to one and clears word and queue state.
// token_stall holds the back only; the front keeps accepting until the queue fills.
module c_token_scanner_top import ctok_pkg::*; #(
  parameter int WORD_MAX   = WORD_MAX_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        token_valid,
  input  logic        token_stall,
  output logic [15:0] line_number,
  output logic [15:0] token_number,
  output logic [2:0]  token_class,
  output logic [7:0]  lexeme_char,
  output logic        last_char
);

  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head_cmd;
  logic q_full;
  logic q_empty;

  // classify bytes into commands
  ctok_front u_front (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // decoupling queue
  ctok_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // execute commands and emit token items
  ctok_back #(
    .WORD_MAX   (WORD_MAX),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .line_number  (line_number),
    .token_number (token_number),
    .token_class  (token_class),
    .lexeme_char  (lexeme_char),
    .last_char    (last_char)
  );

endmodule
